### design/encoder_spi_frame_decoder_assert.svh
// Assertion helpers used by the decoder back end (esfd_back).
`ifndef ENCODER_SPI_FRAME_DECODER_ASSERT_SVH
`define ENCODER_SPI_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication.
`define ESFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ESFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/esfd_pkg.sv
package esfd_pkg;

	localparam logic [1:0] OP_FRAME = 2'd0;
	localparam logic [1:0] OP_FAIL  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_FAILED  = 2'd1;
	localparam logic [1:0] STATUS_CLEARED = 2'd2;

	localparam logic [7:0] CRC_POLY = 8'h97;
	localparam int POS_W = 19;
	localparam int Q_DEPTH = 2;
	localparam int Q_AW = $clog2(Q_DEPTH);
	localparam int Q_CW = $clog2(Q_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_FRAME = 2'd0,
		KIND_FAIL  = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] frame_word;
	} esfd_in_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [POS_W-1:0] position;
		logic             warning_flag;
		logic             error_flag;
		logic             crc_ok;
		logic             reading_present;
		logic [31:0]      reading_count;
		logic [31:0]      crc_fail_count;
		logic [31:0]      fault_count;
		logic [31:0]      warn_count;
	} esfd_out_t;

	// in-flight frame inside the front pipeline
	typedef struct packed {
		kind_t            kind;
		logic [POS_W-1:0] position;
		logic             warning;
		logic             error;
		logic [7:0]       b1;
		logic [7:0]       b2;
		logic [7:0]       b3;
		logic [7:0]       crc;
	} front_t;

	// classified record handed to the back end
	typedef struct packed {
		kind_t            kind;
		logic [POS_W-1:0] position;
		logic             warning;
		logic             error;
		logic             crc_ok;
	} rec_t;

	function automatic logic [7:0] crc8_byte(logic [7:0] crc_in, logic [7:0] data);
		logic [7:0] c;
		c = crc_in ^ data;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

### design/encoder_spi_frame_decoder.sv
// channel | signals                                  | beat
// frame   | frame_valid, frame_ready, frame          | op + 32-bit SPI response
// result  | result_valid, result_ready, result       | status, latched reading, counters
//
// One beat per cycle sustained on both channels while result_ready holds. A beat
// passes the first front stage, loaded at acceptance, then the second front stage
// (CRC-8, one byte per stage), the 2-entry queue, the output register. Reset clears all
// counters and the latched reading at once. A stalled result stops the back end first;
// the queue and front keep filling until full, then frame_ready drops.
// Beats with an unused op are taken and dropped in the front stage.
module encoder_spi_frame_decoder import esfd_pkg::*; #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      frame_valid,
	output logic      frame_ready,
	input  esfd_in_t  frame,
	output logic      result_valid,
	input  logic      result_ready,
	output esfd_out_t result
);

	logic fq_valid, fq_ready, qb_valid, qb_ready;
	rec_t fq_rec, qb_rec;

	esfd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready),
		.frame       (frame),
		.rec_valid   (fq_valid),
		.rec_ready   (fq_ready),
		.rec         (fq_rec)
	);

	esfd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_rec),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_data   (qb_rec)
	);

	esfd_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.rec_valid    (qb_valid),
		.rec_ready    (qb_ready),
		.rec          (qb_rec),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

### design/esfd_front.sv
module esfd_front import esfd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     frame_valid,
	output logic     frame_ready,
	input  esfd_in_t frame,
	output logic     rec_valid,
	input  logic     rec_ready,
	output rec_t     rec
);

	logic   v_s1, v_s2;
	front_t d_s1, d_s2;
	front_t d_in;
	front_t d_adv;
	logic   op_known;
	logic   adv2;

	always_comb begin
		op_known = (frame.op == OP_FRAME) || (frame.op == OP_FAIL) || (frame.op == OP_CLEAR);
		unique case (frame.op)
			OP_FAIL:  d_in.kind = KIND_FAIL;
			OP_CLEAR: d_in.kind = KIND_CLEAR;
			default:  d_in.kind = KIND_FRAME;
		endcase
		d_in.position = frame.frame_word[31:13];
		d_in.warning  = ~frame.frame_word[8];
		d_in.error    = ~frame.frame_word[9];
		d_in.b1       = frame.frame_word[23:16];
		d_in.b2       = frame.frame_word[15:8];
		d_in.b3       = frame.frame_word[7:0];
		d_in.crc      = crc8_byte(8'h00, frame.frame_word[31:24]);
	end

	always_comb begin
		d_adv     = d_s1;
		d_adv.crc = crc8_byte(d_s1.crc, d_s1.b1);
	end

	assign adv2        = !v_s2 || rec_ready;
	assign frame_ready = !v_s1 || adv2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (frame_ready) begin
				v_s1 <= frame_valid && op_known;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame_ready && frame_valid) begin
			d_s1 <= d_in;
		end
		if (adv2 && v_s1) begin
			d_s2 <= d_adv;
		end
	end

	assign rec_valid    = v_s2;
	assign rec.kind     = d_s2.kind;
	assign rec.position = d_s2.position;
	assign rec.warning  = d_s2.warning;
	assign rec.error    = d_s2.error;
	assign rec.crc_ok   = (d_s2.b3 == ~crc8_byte(d_s2.crc, d_s2.b2));

endmodule

### design/esfd_queue.sv
module esfd_queue import esfd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  rec_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output rec_t pop_data
);

	rec_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CW-1:0] count_q;
	logic            push, pop;

	assign push_ready = (count_q != Q_CW'(Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + Q_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + Q_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + Q_CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - Q_CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### design/esfd_back.sv
module esfd_back import esfd_pkg::*; #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      rec_valid,
	output logic      rec_ready,
	input  rec_t      rec,
	output logic      result_valid,
	input  logic      result_ready,
	output esfd_out_t result
);

	`include "encoder_spi_frame_decoder_assert.svh"

	logic [POS_W-1:0]       pos_q, pos_d;
	logic                   warn_q, warn_d, err_q, err_d, crc_ok_q, crc_ok_d;
	logic                   have_q, have_d;
	logic [COUNT_WIDTH-1:0] total_q, total_d, crcf_q, crcf_d;
	logic [COUNT_WIDTH-1:0] fault_q, fault_d, warnc_q, warnc_d;
	logic [1:0]             status_d;
	logic                   result_valid_q;
	esfd_out_t              result_q;
	logic                   pop;

	assign rec_ready = !result_valid_q || result_ready;
	assign pop       = rec_valid && rec_ready;

	always_comb begin
		pos_d    = pos_q;
		warn_d   = warn_q;
		err_d    = err_q;
		crc_ok_d = crc_ok_q;
		have_d   = have_q;
		total_d  = total_q;
		crcf_d   = crcf_q;
		fault_d  = fault_q;
		warnc_d  = warnc_q;
		status_d = STATUS_OK;
		unique case (rec.kind)
			KIND_FRAME: begin
				status_d = STATUS_OK;
				pos_d    = rec.position;
				warn_d   = rec.warning;
				err_d    = rec.error;
				crc_ok_d = rec.crc_ok;
				have_d   = 1'b1;
				total_d  = total_q + COUNT_WIDTH'(1);
				if (!rec.crc_ok) begin
					crcf_d = crcf_q + COUNT_WIDTH'(1);
				end
				if (rec.error) begin
					fault_d = fault_q + COUNT_WIDTH'(1);
				end
				if (rec.warning) begin
					warnc_d = warnc_q + COUNT_WIDTH'(1);
				end
			end
			KIND_FAIL: begin
				status_d = STATUS_FAILED;
				total_d  = total_q + COUNT_WIDTH'(1);
			end
			KIND_CLEAR: begin
				status_d = STATUS_CLEARED;
				total_d  = '0;
				crcf_d   = '0;
				fault_d  = '0;
				warnc_d  = '0;
			end
			default: begin
				status_d = STATUS_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= '0;
			warn_q         <= 1'b0;
			err_q          <= 1'b0;
			crc_ok_q       <= 1'b0;
			have_q         <= 1'b0;
			total_q        <= '0;
			crcf_q         <= '0;
			fault_q        <= '0;
			warnc_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				pos_q    <= pos_d;
				warn_q   <= warn_d;
				err_q    <= err_d;
				crc_ok_q <= crc_ok_d;
				have_q   <= have_d;
				total_q  <= total_d;
				crcf_q   <= crcf_d;
				fault_q  <= fault_d;
				warnc_q  <= warnc_d;
			end
			if (rec_ready) begin
				result_valid_q <= rec_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q.status          <= status_d;
			result_q.position        <= pos_d;
			result_q.warning_flag    <= warn_d;
			result_q.error_flag      <= err_d;
			result_q.crc_ok          <= crc_ok_d;
			result_q.reading_present <= have_d;
			result_q.reading_count   <= 32'(total_d);
			result_q.crc_fail_count  <= 32'(crcf_d);
			result_q.fault_count     <= 32'(fault_d);
			result_q.warn_count      <= 32'(warnc_d);
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`ESFD_ASSERT_NEXT(a_clear_zeroes, clk, arst_n, pop && rec.kind == KIND_CLEAR,
		total_q == '0 && crcf_q == '0 && fault_q == '0 && warnc_q == '0,
		"clear did not zero the counters")
	`ESFD_ASSERT_NEXT(a_frame_latches, clk, arst_n, pop && rec.kind == KIND_FRAME,
		have_q && result_q.reading_present, "frame did not latch a reading")
	`ESFD_ASSERT_NEXT(a_fail_keeps, clk, arst_n, pop && rec.kind == KIND_FAIL,
		$stable(pos_q) && total_q == $past(total_q) + COUNT_WIDTH'(1),
		"failed transfer changed the reading or miscounted")
	`ESFD_ASSERT_NOW(a_out_matches, clk, arst_n, result_valid_q,
		result_q.reading_count == 32'(total_q) && result_q.position == pos_q,
		"result out of step with state")

endmodule
